### rtl/stepper_speed_ramp_to_period_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the stepper speed ramp block
// Each macro expects signals named clk and arst_n in the module that uses it.
// ---------------------------------------------------------------------------
`ifndef STEPPER_SPEED_RAMP_TO_PERIOD_TOP_MACROS_SVH
`define STEPPER_SPEED_RAMP_TO_PERIOD_TOP_MACROS_SVH

// check c in the same cycle as a
`define SSPR_ASSERT_NOW(label, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error(msg);

// check c in the cycle after a
`define SSPR_ASSERT_NEXT(label, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error(msg);

`endif

### rtl/sspr_pkg.sv
// ---------------------------------------------------------------------------
// sspr_pkg
// Types, register indexes and constants of the stepper speed ramp block.
// ---------------------------------------------------------------------------
package sspr_pkg;

	localparam int SPEED_W  = 16;
	localparam int DT_W     = 16;
	localparam int MODE_W   = 3;
	localparam int PERIOD_W = 32;
	localparam int ACCEL_W  = 15;
	localparam int DIST_W   = 48;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 2;

	// period quotient: numerator shifted up by eight bits
	localparam int QUOT_W   = PERIOD_W + 8;
	// |l+r| * dt: 17 by 16 bits
	localparam int PROD_W   = SPEED_W + 1 + DT_W;
	// product times seven
	localparam int DISTQ_W  = PROD_W + 2;
	// divide by twenty: drop two bits, then multiply by 2^35 / 5 rounded up
	localparam int DIST_Y_W    = DISTQ_W - 2;
	localparam int DIST_LO_W   = 17;
	localparam int DIST_RCP_W  = 33;
	localparam int DIST_RCP_SH = 35;
	localparam logic [DIST_RCP_W-1:0] DIST_RCP = 33'h1_9999_999A;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_NUM  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_FLOOR = 2'd2;

	localparam logic [ACCEL_W-1:0]  RST_MAX_ACCEL    = 15'd256;
	localparam logic [PERIOD_W-1:0] RST_PERIOD_NUM   = 32'd100000;
	localparam logic [PERIOD_W-1:0] RST_PERIOD_FLOOR = 32'd100;

	localparam logic [MODE_W-1:0] MODE_MIN = 3'd1;
	localparam logic [MODE_W-1:0] MODE_MAX = 3'd4;

	typedef struct packed {
		logic signed [SPEED_W-1:0] target_left;
		logic signed [SPEED_W-1:0] target_right;
		logic [DT_W-1:0]           time_step;
		logic [MODE_W-1:0]         microstep_mode;
		logic                      clear_distance;
	} req_t;

	typedef struct packed {
		logic [PERIOD_W-1:0]       left_period;
		logic                      left_reverse;
		logic [PERIOD_W-1:0]       right_period;
		logic                      right_reverse;
		logic [MODE_W-1:0]         mode_out;
		logic signed [SPEED_W-1:0] speed_left_now;
		logic signed [SPEED_W-1:0] speed_right_now;
		logic signed [DIST_W-1:0]  distance_now;
		logic                      frame_valid;
		logic                      mode_error;
	} res_t;

	typedef struct packed {
		logic capture;
		logic slew;
		logic prep;
		logic start;
		logic finish;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic change;
		logic mode_ok;
		logic div_busy;
	} stat_t;

endpackage

### rtl/sspr_div.sv
// ---------------------------------------------------------------------------
// sspr_div
// Restoring divider lane, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module sspr_div #(
	parameter int DW = sspr_pkg::QUOT_W,
	parameter int VW = sspr_pkg::SPEED_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [CW-1:0] cnt_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [VW:0]   trial;
	logic          ge;
	logic [VW:0]   diff;

	assign trial = {rem_q, quo_q[DW-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(DW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
		end
	end

	assign busy     = cnt_q != '0;
	assign quotient = quo_q;

endmodule

### rtl/sspr_datapath.sv
// ---------------------------------------------------------------------------
// sspr_datapath
// Configuration, held speeds, odometer, divider lanes and result register.
// ---------------------------------------------------------------------------
module sspr_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sspr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sspr_pkg::CFG_W-1:0]          cfg_data,
	input  sspr_pkg::req_t                      req_data,
	output sspr_pkg::res_t                      res_data,
	input  sspr_pkg::cmd_t                      cmd,
	output sspr_pkg::stat_t                     stat
);

	localparam int SW = sspr_pkg::SPEED_W;
	localparam int PW = sspr_pkg::PERIOD_W;
	localparam int QW = sspr_pkg::QUOT_W;
	localparam int DW = sspr_pkg::DIST_W;
	localparam int YW = sspr_pkg::DIST_Y_W;
	localparam int LW = sspr_pkg::DIST_LO_W;
	localparam int RW = sspr_pkg::DIST_RCP_W;
	localparam int FW = YW + RW;

	function automatic logic signed [SW-1:0] slew_f(
		input logic signed [SW-1:0] held,
		input logic signed [SW-1:0] target,
		input logic [sspr_pkg::ACCEL_W-1:0] acc
	);
		logic signed [SW:0] diff;
		logic signed [SW:0] lim;
		logic signed [SW:0] nxt;
		diff = {held[SW-1], held} - {target[SW-1], target};
		lim  = {2'b00, acc};
		if (diff > lim) begin
			nxt = {held[SW-1], held} - lim;
		end else if (diff < -lim) begin
			nxt = {held[SW-1], held} + lim;
		end else begin
			nxt = {target[SW-1], target};
		end
		return nxt[SW-1:0];
	endfunction

	function automatic logic [PW-1:0] period_f(
		input logic [QW-1:0] q,
		input logic          zero,
		input logic [PW-1:0] flr
	);
		logic [PW-1:0] p;
		if (zero) begin
			p = '0;
		end else if (|q[QW-1:PW]) begin
			p = '1;
		end else begin
			p = q[PW-1:0];
		end
		if (p != '0 && p < flr) begin
			p = flr;
		end
		return p;
	endfunction

	logic [sspr_pkg::ACCEL_W-1:0] accel_q;
	logic [PW-1:0]                num_q;
	logic [PW-1:0]                floor_q;

	sspr_pkg::req_t               req_q;
	logic signed [SW-1:0]         held_l_q;
	logic signed [SW-1:0]         held_r_q;
	logic [sspr_pkg::MODE_W-1:0]  last_mode_q;
	logic signed [DW-1:0]         odo_q;
	logic                         frame_q;
	logic                         err_q;
	logic                         sneg_q;
	logic [sspr_pkg::PROD_W-1:0]  prod_q;
	logic [PW-1:0]                lp_q;
	logic [PW-1:0]                rp_q;
	sspr_pkg::res_t               res_q;
	logic                         dstep_s1;
	logic                         dstep_s2;
	logic [LW+RW-1:0]             dist_lo_s1;
	logic [YW-LW+RW-1:0]          dist_hi_s2;
	logic [sspr_pkg::DISTQ_W-1:0] quo_d_q;

	logic [1:0]                   shift;
	logic [SW:0]                  sum_s;
	logic [SW:0]                  mag_s;
	logic [SW-1:0]                mag_l;
	logic [SW-1:0]                mag_r;
	logic [QW-1:0]                num_ext;
	logic [sspr_pkg::DISTQ_W:0]   prod7;
	logic [YW-1:0]                dist_y;
	logic [FW-1:0]                dist_full;
	logic [PW-1:0]                flr;
	logic [QW-1:0]                quo_l;
	logic [QW-1:0]                quo_r;
	logic                         busy_l;
	logic                         busy_r;
	logic [DW:0]                  inc;
	logic [DW:0]                  odo_sum;
	logic signed [DW-1:0]         odo_sat;

	assign shift   = 2'(req_q.microstep_mode - 3'd1);
	assign sum_s   = {held_l_q[SW-1], held_l_q} + {held_r_q[SW-1], held_r_q};
	assign mag_s   = sum_s[SW] ? (~sum_s + 1'b1) : sum_s;
	assign mag_l   = held_l_q[SW-1] ? (~held_l_q + 1'b1) : held_l_q;
	assign mag_r   = held_r_q[SW-1] ? (~held_r_q + 1'b1) : held_r_q;
	assign num_ext = {num_q >> shift, 8'h00};
	assign prod7   = ({3'b000, prod_q} << 3) - {3'b000, prod_q};
	assign dist_y  = prod7[sspr_pkg::DISTQ_W-1:2];
	assign flr     = floor_q >> shift;

	assign stat.change = (req_q.target_left != held_l_q) || (req_q.target_right != held_r_q)
		|| (req_q.microstep_mode != last_mode_q);
	assign stat.mode_ok = (req_q.microstep_mode >= sspr_pkg::MODE_MIN)
		&& (req_q.microstep_mode <= sspr_pkg::MODE_MAX);
	assign stat.div_busy = busy_l | busy_r;

	sspr_div #(.DW(QW), .VW(SW)) u_div_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start),
		.dividend (num_ext),
		.divisor  (mag_l),
		.busy     (busy_l),
		.quotient (quo_l)
	);

	sspr_div #(.DW(QW), .VW(SW)) u_div_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start),
		.dividend (num_ext),
		.divisor  (mag_r),
		.busy     (busy_r),
		.quotient (quo_r)
	);

	assign dist_full = {dist_hi_s2, {LW{1'b0}}} + FW'(dist_lo_s1);

	assign inc     = sneg_q ? (~{(DW + 1 - sspr_pkg::DISTQ_W)'(0), quo_d_q} + 1'b1)
		: {(DW + 1 - sspr_pkg::DISTQ_W)'(0), quo_d_q};
	assign odo_sum = {odo_q[DW-1], odo_q} + inc;
	always_comb begin
		if (odo_sum[DW] != odo_sum[DW-1]) begin
			odo_sat = odo_sum[DW] ? {1'b1, {(DW - 1){1'b0}}} : {1'b0, {(DW - 1){1'b1}}};
		end else begin
			odo_sat = odo_sum[DW-1:0];
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q <= sspr_pkg::RST_MAX_ACCEL;
			num_q   <= sspr_pkg::RST_PERIOD_NUM;
			floor_q <= sspr_pkg::RST_PERIOD_FLOOR;
		end else if (cfg_we) begin
			case (cfg_index)
				sspr_pkg::REG_MAX_ACCEL:    accel_q <= cfg_data[sspr_pkg::ACCEL_W-1:0];
				sspr_pkg::REG_PERIOD_NUM:   num_q   <= cfg_data;
				sspr_pkg::REG_PERIOD_FLOOR: floor_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_l_q    <= '0;
			held_r_q    <= '0;
			last_mode_q <= '0;
			odo_q       <= '0;
			frame_q     <= 1'b0;
			err_q       <= 1'b0;
		end else begin
			if (cmd.capture && req_data.clear_distance) begin
				odo_q <= '0;
			end
			if (cmd.slew) begin
				frame_q <= stat.change && stat.mode_ok;
				err_q   <= stat.change && !stat.mode_ok;
				if (stat.change) begin
					held_l_q <= slew_f(held_l_q, req_q.target_left, accel_q);
					held_r_q <= slew_f(held_r_q, req_q.target_right, accel_q);
				end
			end
			if (cmd.finish) begin
				odo_q       <= odo_sat;
				last_mode_q <= req_q.microstep_mode;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dstep_s1 <= 1'b0;
			dstep_s2 <= 1'b0;
		end else begin
			dstep_s1 <= cmd.start;
			dstep_s2 <= dstep_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_data;
		end
		if (cmd.prep) begin
			sneg_q <= sum_s[SW];
			prod_q <= sspr_pkg::PROD_W'(mag_s) * sspr_pkg::PROD_W'(req_q.time_step);
		end
		if (cmd.start) begin
			dist_lo_s1 <= (LW + RW)'(dist_y[LW-1:0]) * (LW + RW)'(sspr_pkg::DIST_RCP);
		end
		if (dstep_s1) begin
			dist_hi_s2 <= (YW - LW + RW)'(dist_y[YW-1:LW]) * (YW - LW + RW)'(sspr_pkg::DIST_RCP);
		end
		if (dstep_s2) begin
			quo_d_q <= sspr_pkg::DISTQ_W'(dist_full[FW-1:sspr_pkg::DIST_RCP_SH]);
		end
		if (cmd.finish) begin
			lp_q <= period_f(quo_l, held_l_q == '0, flr);
			rp_q <= period_f(quo_r, held_r_q == '0, flr);
		end
		if (cmd.load_out) begin
			res_q.left_period     <= frame_q ? lp_q : '0;
			res_q.left_reverse    <= frame_q & held_l_q[SW-1];
			res_q.right_period    <= frame_q ? rp_q : '0;
			res_q.right_reverse   <= frame_q & held_r_q[SW-1];
			res_q.mode_out        <= frame_q ? req_q.microstep_mode : '0;
			res_q.speed_left_now  <= held_l_q;
			res_q.speed_right_now <= held_r_q;
			res_q.distance_now    <= odo_q;
			res_q.frame_valid     <= frame_q;
			res_q.mode_error      <= err_q;
		end
	end

	assign res_data = res_q;

endmodule

### rtl/sspr_ctrl.sv
// ---------------------------------------------------------------------------
// sspr_ctrl
// Sequencer for one request beat: slew, divide and update when the beat makes a frame, hand over the result.
// ---------------------------------------------------------------------------
`include "stepper_speed_ramp_to_period_top_macros.svh"

module sspr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	output logic            res_valid,
	input  logic            res_stall,
	input  sspr_pkg::stat_t stat,
	output sspr_pkg::cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SLEW  = 3'd1;
	localparam logic [2:0] ST_PREP  = 3'd2;
	localparam logic [2:0] ST_START = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       res_valid_q;
	logic       out_free;

	assign req_stall = state_q != ST_IDLE;
	assign out_free  = !res_valid_q || !res_stall;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_SLEW;
				end
			end
			ST_SLEW: begin
				cmd.slew = 1'b1;
				state_d  = (stat.change && stat.mode_ok) ? ST_PREP : ST_OUT;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_START;
			end
			ST_START: begin
				cmd.start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (!stat.div_busy) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;

	`SSPR_ASSERT_NEXT(a_accept_slews, req_valid && !req_stall, state_q == ST_SLEW,
		"accepted beat did not move to slew")
	`SSPR_ASSERT_NEXT(a_start_busy, cmd.start, stat.div_busy,
		"divider lanes idle after start")
	`SSPR_ASSERT_NOW(a_fin_done, state_q == ST_FIN, !stat.div_busy,
		"finish while a divider lane is busy")
	`SSPR_ASSERT_NEXT(a_out_hold, state_q == ST_OUT && res_valid && res_stall,
		state_q == ST_OUT, "result overwritten while stalled")

endmodule

### rtl/stepper_speed_ramp_to_period_top.sv
// A frame passes through the slew, prep, start, divide, finish and output states before the result is registered.
// A request that changes nothing, or carries an invalid mode, goes from slew straight to the output state.
// The block takes one request at a time: req_stall stays high until the result is loaded for output.
// Left and right dividers run side by side; the distance is scaled by a reciprocal meanwhile.
// Reset (arst_n low, asynchronous): speeds, mode, distance cleared; registers to defaults.
// ---------------------------------------------------------------------------
// stepper_speed_ramp_to_period_top
// Slew-limited wheel speeds turned into step periods, with odometry.
// ---------------------------------------------------------------------------
module stepper_speed_ramp_to_period_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  sspr_pkg::req_t                 req_data,
	output logic                           res_valid,
	input  logic                           res_stall,
	output sspr_pkg::res_t                 res_data,
	input  logic                           cfg_we,
	input  logic [sspr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sspr_pkg::CFG_W-1:0]     cfg_data
);

	sspr_pkg::cmd_t  cmd;
	sspr_pkg::stat_t stat;

	sspr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	sspr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_data  (req_data),
		.res_data  (res_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

### dv/tb_stepper_speed_ramp_to_period_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_stepper_speed_ramp_to_period_top
// Drives wheel speed requests into the stepper ramp block and checks every
// result beat against an in-bench model of the slew, period and odometry
// maths. A short directed list is followed by random batches under several
// register settings, with random gaps on requests and random stalls on results.
// ---------------------------------------------------------------------------
module tb_stepper_speed_ramp_to_period_top;
	import sspr_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam longint TRIP_MAX = 64'sd140737488355327;
	localparam longint TRIP_MIN = -TRIP_MAX - 64'sd1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req_data = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	res_t                 res_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	req_t drive_cmds[$];
	res_t frames_due[$];
	req_t last_cmd = '0;

	// model state and registers
	int                wheel_l = 0;
	int                wheel_r = 0;
	logic [MODE_W-1:0] seen_mode = '0;
	longint            trip = 0;
	logic [ACCEL_W-1:0]  accel_cfg = RST_MAX_ACCEL;
	logic [PERIOD_W-1:0] num_cfg = RST_PERIOD_NUM;
	logic [PERIOD_W-1:0] floor_cfg = RST_PERIOD_FLOOR;

	logic calm = 1'b0;
	int   send_wait = 0;
	int   take_wait = 0;
	logic hold_valid;
	int   fault_count = 0;
	int   cyc_count = 0;

	stepper_speed_ramp_to_period_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 7);
	endfunction

	function automatic int slew_toward(input int held, input int target);
		int diff;
		int lim;
		diff = held - target;
		lim = int'(accel_cfg);
		if (diff > lim)
			return held - lim;
		if (diff < -lim)
			return held + lim;
		return target;
	endfunction

	function automatic logic [PERIOD_W-1:0] step_period(input int speed, input int unsigned shift);
		longint unsigned mag;
		longint unsigned q;
		longint unsigned flr;
		if (speed == 0)
			return '0;
		mag = 64'((speed < 0) ? -speed : speed);
		q = {24'b0, (num_cfg >> shift), 8'b0} / mag;
		if (q > 64'hFFFF_FFFF)
			q = 64'hFFFF_FFFF;
		flr = floor_cfg >> shift;
		if (q != 0 && q < flr)
			q = flr;
		return q[PERIOD_W-1:0];
	endfunction

	function automatic res_t ramp_predict(input req_t c);
		res_t f;
		int tl;
		int tr;
		int s;
		int unsigned shift;
		longint unsigned mag;
		longint inc;
		longint sum;
		f = '0;
		tl = $signed(c.target_left);
		tr = $signed(c.target_right);
		if (c.clear_distance)
			trip = 0;
		if (tl != wheel_l || tr != wheel_r || c.microstep_mode != seen_mode) begin
			wheel_l = slew_toward(wheel_l, tl);
			wheel_r = slew_toward(wheel_r, tr);
			if (c.microstep_mode < MODE_MIN || c.microstep_mode > MODE_MAX) begin
				f.mode_error = 1'b1;
			end else begin
				shift = 32'(c.microstep_mode - MODE_MIN);
				s = wheel_l + wheel_r;
				mag = 64'((s < 0) ? -s : s);
				mag = mag * c.time_step * 7 / 20;
				inc = (s < 0) ? -longint'(mag) : longint'(mag);
				sum = trip + inc;
				if (sum > TRIP_MAX)
					sum = TRIP_MAX;
				if (sum < TRIP_MIN)
					sum = TRIP_MIN;
				trip = sum;
				f.left_period = step_period(wheel_l, shift);
				f.left_reverse = wheel_l < 0;
				f.right_period = step_period(wheel_r, shift);
				f.right_reverse = wheel_r < 0;
				seen_mode = c.microstep_mode;
				f.mode_out = c.microstep_mode;
				f.frame_valid = 1'b1;
			end
		end
		f.speed_left_now = wheel_l[SPEED_W-1:0];
		f.speed_right_now = wheel_r[SPEED_W-1:0];
		f.distance_now = trip[DIST_W-1:0];
		return f;
	endfunction

	task automatic cmp_field(input string label, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h actual %0h", $time, label, want, got);
			fault_count++;
		end
	endtask

	task automatic check_frame(input res_t want, input res_t got);
		cmp_field("left_period", want.left_period, got.left_period);
		cmp_field("left_reverse", want.left_reverse, got.left_reverse);
		cmp_field("right_period", want.right_period, got.right_period);
		cmp_field("right_reverse", want.right_reverse, got.right_reverse);
		cmp_field("mode_out", want.mode_out, got.mode_out);
		cmp_field("speed_left_now", want.speed_left_now, got.speed_left_now);
		cmp_field("speed_right_now", want.speed_right_now, got.speed_right_now);
		cmp_field("distance_now", want.distance_now, got.distance_now);
		cmp_field("frame_valid", want.frame_valid, got.frame_valid);
		cmp_field("mode_error", want.mode_error, got.mode_error);
	endtask

	// request side: hold each beat until taken, then wait out a drawn gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data <= '0;
			send_wait = draw_gap();
		end else begin
			hold_valid = req_valid;
			if (req_valid && !req_stall) begin
				frames_due.push_back(ramp_predict(req_data));
				hold_valid = 1'b0;
				send_wait = draw_gap();
			end
			if (!hold_valid) begin
				if (send_wait > 0)
					send_wait--;
				else if (drive_cmds.size() != 0) begin
					req_data <= drive_cmds.pop_front();
					hold_valid = 1'b1;
				end
			end
			req_valid <= hold_valid;
		end
	end

	// result side: stall each beat for a drawn wait, then take and check it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			take_wait = draw_gap();
		end else begin
			if (res_valid && !res_stall) begin
				if (frames_due.size() == 0) begin
					$display("%0t: result beat expected none actual %p", $time, res_data);
					fault_count++;
				end else begin
					check_frame(frames_due.pop_front(), res_data);
				end
				take_wait = draw_gap();
			end else if (res_valid && take_wait > 0) begin
				take_wait--;
			end
			res_stall <= (take_wait > 0);
		end
	end

	always @(posedge clk) begin
		cyc_count <= cyc_count + 1;
		if (cyc_count == CYCLE_LIMIT) begin
			$display("stepper_speed_ramp_to_period_top verification failed");
			$finish;
		end
	end

	function automatic req_t mk(input int tl, input int tr, input int dt,
			input logic [MODE_W-1:0] mode, input logic clr);
		req_t c;
		c.target_left = SPEED_W'(tl);
		c.target_right = SPEED_W'(tr);
		c.time_step = DT_W'(dt);
		c.microstep_mode = mode;
		c.clear_distance = clr;
		return c;
	endfunction

	function automatic logic signed [SPEED_W-1:0] pick_speed();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return '0;
			3: return SPEED_W'($urandom_range(0, 6) - 3);
			default: return SPEED_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic req_t next_cmd(input req_t prev);
		req_t c;
		int roll;
		int sel;
		c = prev;
		roll = $urandom_range(0, 99);
		c.clear_distance = ($urandom_range(0, 15) == 0);
		case ($urandom_range(0, 7))
			0: c.time_step = '0;
			1: c.time_step = '1;
			default: c.time_step = DT_W'($urandom_range(0, 65535));
		endcase
		if (roll < 30) begin
			// repeat the targets so the ramp settles and requests go quiet
		end else if (roll < 40) begin
			sel = $urandom_range(0, 3);
			c.microstep_mode = (sel == 0) ? 3'd0 : 3'(sel + 4);
		end else if (roll < 50) begin
			c.microstep_mode = MODE_W'($urandom_range(MODE_MIN, MODE_MAX));
		end else begin
			c.target_left = pick_speed();
			c.target_right = pick_speed();
			if ($urandom_range(0, 2) == 0 || prev.microstep_mode < MODE_MIN
					|| prev.microstep_mode > MODE_MAX)
				c.microstep_mode = MODE_W'($urandom_range(MODE_MIN, MODE_MAX));
		end
		return c;
	endfunction

	task automatic settle();
		do
			@(negedge clk);
		while (drive_cmds.size() != 0 || req_valid || frames_due.size() != 0);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_settings(input logic [ACCEL_W-1:0] accel,
			input logic [PERIOD_W-1:0] num, input logic [PERIOD_W-1:0] flr);
		accel_cfg = accel;
		num_cfg = num;
		floor_cfg = flr;
		put_reg(REG_MAX_ACCEL, CFG_W'(accel));
		put_reg(REG_PERIOD_NUM, num);
		put_reg(REG_PERIOD_FLOOR, flr);
	endtask

	task automatic run_batch(input int count);
		@(negedge clk);
		for (int i = 0; i < count; i++) begin
			last_cmd = next_cmd(last_cmd);
			drive_cmds.push_back(last_cmd);
		end
		settle();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: first frame, quiet repeat, full-scale ramp, every mode, clear
		drive_cmds.push_back(mk(0, 0, 0, MODE_MIN, 1'b0));
		drive_cmds.push_back(mk(0, 0, 0, MODE_MIN, 1'b0));
		drive_cmds.push_back(mk(32767, -32768, 65535, MODE_MIN, 1'b0));
		drive_cmds.push_back(mk(32767, -32768, 65535, MODE_MIN, 1'b1));
		drive_cmds.push_back(mk(32767, -32768, 65535, 3'd2, 1'b0));
		drive_cmds.push_back(mk(32767, -32768, 65535, 3'd3, 1'b0));
		drive_cmds.push_back(mk(32767, -32768, 65535, MODE_MAX, 1'b0));
		drive_cmds.push_back(mk(32767, -32768, 40000, 3'd0, 1'b0));
		drive_cmds.push_back(mk(32767, -32768, 40000, 3'd5, 1'b0));
		drive_cmds.push_back(mk(32767, -32768, 40000, 3'd6, 1'b0));
		drive_cmds.push_back(mk(32767, -32768, 40000, 3'd7, 1'b0));
		// ramp toward the smallest speeds, then one more such request with clear
		for (int k = 0; k < 10; k++)
			drive_cmds.push_back(mk(1, -1, 65535, MODE_MAX, 1'b0));
		drive_cmds.push_back(mk(1, -1, 65535, MODE_MAX, 1'b1));
		drive_cmds.push_back(mk(0, 0, 1234, MODE_MIN, 1'b0));
		last_cmd = mk(0, 0, 1234, MODE_MIN, 1'b0);
		settle();

		load_settings('1, '1, '0);
		calm = 1'b1;
		run_batch(200);
		calm = 1'b0;

		load_settings('0, '0, '1);
		run_batch(80);

		load_settings(15'd1, 32'd1, 32'd1);
		run_batch(100);

		for (int p = 0; p < 6; p++) begin
			load_settings(
				ACCEL_W'($urandom_range(0, 1) ? $urandom_range(1, 600)
					: $urandom_range(0, 32767)),
				PERIOD_W'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 200000)),
				PERIOD_W'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20000)));
			calm = (p == 2);
			run_batch(180);
		end
		calm = 1'b0;

		load_settings(RST_MAX_ACCEL, RST_PERIOD_NUM, RST_PERIOD_FLOOR);
		run_batch(150);

		repeat (60) @(posedge clk);
		if (fault_count == 0 && frames_due.size() == 0)
			$display("stepper_speed_ramp_to_period_top verification clean");
		else
			$display("stepper_speed_ramp_to_period_top verification failed");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/sspr_pkg.sv
rtl/sspr_div.sv
rtl/sspr_datapath.sv
rtl/sspr_ctrl.sv
rtl/stepper_speed_ramp_to_period_top.sv
dv/tb_stepper_speed_ramp_to_period_top.sv
